// ===== sv/sxt_pkg.sv =====
// Shared types, character codes and byte-class helpers for the s-expression tokenizer.
// Used by sxt_front, sxt_fifo, sxt_back and s_expression_tokenizer; depends on nothing.
package sxt_pkg;

  localparam int POS_BITS   = 24;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [POS_BITS-1:0] pos_t;
  localparam pos_t POS_MAX = {POS_BITS{1'b1}};

  // Character codes the scanner keys on
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  typedef enum logic [3:0] {
    KIND_END      = 4'd0,
    KIND_INVALID  = 4'd1,
    KIND_LPAREN   = 4'd2,
    KIND_RPAREN   = 4'd3,
    KIND_SYMBOL   = 4'd4,
    KIND_KEYWORD  = 4'd5,
    KIND_STRING   = 4'd6,
    KIND_NUMERIC  = 4'd7,
    KIND_FUNCTION = 4'd8,
    KIND_MACRO    = 4'd9,
    KIND_COMMENT  = 4'd10
  } kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_SIGN,
    MODE_STRING,
    MODE_NUMERIC,
    MODE_MACRO,
    MODE_COMMENT,
    MODE_KEYWORD,
    MODE_SYMBOL
  } mode_e;

  typedef struct packed {
    kind_e kind;
    pos_t  start;
    pos_t  len;
    pos_t  line;
    pos_t  col;
    logic  last;
  } token_t;

  // One queue entry: the tokens caused by one input byte
  typedef struct packed {
    token_t tok0;
    token_t tok1;
    logic   two;
  } pair_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  function automatic pos_t sat_inc(pos_t x);
    return (x == POS_MAX) ? x : x + pos_t'(1);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_sym(logic [7:0] b);
    logic alnum;
    alnum = is_digit(b) || ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    return alnum || (b inside {"-", "_", "+", "*", "/", ":", "<", "=", ">",
                               "!", "?", "&", "~", "^"});
  endfunction

  function automatic kind_e mode_kind(mode_e m);
    kind_e k;
    unique case (m)
      MODE_STRING:  k = KIND_STRING;
      MODE_NUMERIC: k = KIND_NUMERIC;
      MODE_MACRO:   k = KIND_MACRO;
      MODE_COMMENT: k = KIND_COMMENT;
      MODE_KEYWORD: k = KIND_KEYWORD;
      MODE_SYMBOL:  k = KIND_SYMBOL;
      default:      k = KIND_FUNCTION;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/sxt_front.sv =====
// Scanner front end: accepts source bytes, tracks scan mode and position,
// and pushes the tokens each byte closes or starts into the token queue. Uses sxt_pkg.
module sxt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         ch_i,
  input  logic               is_end_i,
  input  sxt_pkg::fifo_stat_t fifo_stat_i,
  output logic               push_o,
  output sxt_pkg::pair_t     push_data_o
);

  sxt_pkg::mode_e mode_q, mode_d;
  sxt_pkg::pos_t  pos_q, pos_d;
  sxt_pkg::pos_t  line_q, line_d;
  sxt_pkg::pos_t  col_q, col_d;
  sxt_pkg::pos_t  tstart_q, tstart_d;
  sxt_pkg::pos_t  tline_q, tline_d;
  sxt_pkg::pos_t  tcol_q, tcol_d;

  logic           accept;
  logic           a_v, b_v, do_start;
  sxt_pkg::token_t tok_a, tok_b, tok_close, tok_sign;
  logic           st_emit;
  sxt_pkg::kind_e st_kind;
  sxt_pkg::mode_e st_mode;
  sxt_pkg::pos_t  close_len;

  assign in_ready_o = !fifo_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the byte as a token opener
  always_comb begin
    st_emit = 1'b0;
    st_kind = sxt_pkg::KIND_INVALID;
    st_mode = sxt_pkg::MODE_IDLE;
    if (ch_i == sxt_pkg::CH_LPAREN) begin
      st_emit = 1'b1;
      st_kind = sxt_pkg::KIND_LPAREN;
    end else if (ch_i == sxt_pkg::CH_RPAREN) begin
      st_emit = 1'b1;
      st_kind = sxt_pkg::KIND_RPAREN;
    end else if (ch_i == sxt_pkg::CH_QUOTE) begin
      st_mode = sxt_pkg::MODE_STRING;
    end else if (ch_i == sxt_pkg::CH_PLUS || ch_i == sxt_pkg::CH_MINUS) begin
      st_mode = sxt_pkg::MODE_SIGN;
    end else if (ch_i == sxt_pkg::CH_STAR || ch_i == sxt_pkg::CH_SLASH) begin
      st_emit = 1'b1;
      st_kind = sxt_pkg::KIND_FUNCTION;
    end else if (ch_i == sxt_pkg::CH_HASH) begin
      st_mode = sxt_pkg::MODE_MACRO;
    end else if (ch_i == sxt_pkg::CH_COLON) begin
      st_mode = sxt_pkg::MODE_KEYWORD;
    end else if (ch_i == sxt_pkg::CH_SEMI) begin
      st_mode = sxt_pkg::MODE_COMMENT;
    end else if (sxt_pkg::is_digit(ch_i)) begin
      st_mode = sxt_pkg::MODE_NUMERIC;
    end else if (sxt_pkg::is_sym(ch_i)) begin
      st_mode = sxt_pkg::MODE_SYMBOL;
    end else begin
      st_emit = 1'b1;
      st_kind = sxt_pkg::KIND_INVALID;
    end
  end

  assign close_len = (pos_q >= tstart_q) ? pos_q - tstart_q : '0;

  always_comb begin
    tok_close.kind  = sxt_pkg::mode_kind(mode_q);
    tok_close.start = tstart_q;
    tok_close.len   = close_len;
    tok_close.line  = tline_q;
    tok_close.col   = tcol_q;
    tok_close.last  = 1'b0;
    tok_sign        = tok_close;
    tok_sign.kind   = sxt_pkg::KIND_FUNCTION;
    tok_sign.len    = sxt_pkg::pos_t'(1);
  end

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    line_d   = line_q;
    col_d    = col_q;
    tstart_d = tstart_q;
    tline_d  = tline_q;
    tcol_d   = tcol_q;
    a_v      = 1'b0;
    b_v      = 1'b0;
    do_start = 1'b0;
    tok_a    = tok_close;
    tok_b.kind  = st_kind;
    tok_b.start = pos_q;
    tok_b.len   = sxt_pkg::pos_t'(1);
    tok_b.line  = line_q;
    tok_b.col   = col_q;
    tok_b.last  = 1'b0;

    if (is_end_i) begin
      // Flush the open token, then the end token; back to reset state
      if (mode_q == sxt_pkg::MODE_SIGN) begin
        a_v   = 1'b1;
        tok_a = tok_sign;
      end else if (mode_q != sxt_pkg::MODE_IDLE) begin
        a_v = 1'b1;
      end
      b_v         = 1'b1;
      tok_b.kind  = sxt_pkg::KIND_END;
      tok_b.len   = '0;
      mode_d   = sxt_pkg::MODE_IDLE;
      pos_d    = '0;
      line_d   = sxt_pkg::pos_t'(1);
      col_d    = sxt_pkg::pos_t'(1);
      tstart_d = '0;
      tline_d  = sxt_pkg::pos_t'(1);
      tcol_d   = sxt_pkg::pos_t'(1);
    end else begin
      unique case (mode_q)
        sxt_pkg::MODE_STRING: begin
          if (ch_i == sxt_pkg::CH_QUOTE) begin
            a_v    = 1'b1;
            mode_d = sxt_pkg::MODE_IDLE;
          end
        end
        sxt_pkg::MODE_SIGN: begin
          if (sxt_pkg::is_digit(ch_i)) begin
            mode_d = sxt_pkg::MODE_NUMERIC;
          end else begin
            a_v      = 1'b1;
            tok_a    = tok_sign;
            do_start = 1'b1;
          end
        end
        sxt_pkg::MODE_NUMERIC: begin
          if (!(sxt_pkg::is_digit(ch_i) || ch_i == sxt_pkg::CH_DOT ||
                ch_i == sxt_pkg::CH_SLASH)) begin
            a_v      = 1'b1;
            do_start = 1'b1;
          end
        end
        sxt_pkg::MODE_MACRO, sxt_pkg::MODE_COMMENT: begin
          if (ch_i == sxt_pkg::CH_NEWLINE) begin
            a_v      = 1'b1;
            do_start = 1'b1;
          end
        end
        sxt_pkg::MODE_KEYWORD, sxt_pkg::MODE_SYMBOL: begin
          if (!sxt_pkg::is_sym(ch_i)) begin
            a_v      = 1'b1;
            do_start = 1'b1;
          end
        end
        default: begin
          do_start = 1'b1;
        end
      endcase

      if (do_start) begin
        mode_d = sxt_pkg::MODE_IDLE;
        if (!sxt_pkg::is_space(ch_i)) begin
          tstart_d = (ch_i == sxt_pkg::CH_QUOTE) ? sxt_pkg::sat_inc(pos_q) : pos_q;
          tline_d  = line_q;
          tcol_d   = col_q;
          mode_d   = st_mode;
          b_v      = st_emit;
        end
      end

      if (ch_i == sxt_pkg::CH_NEWLINE) begin
        line_d = sxt_pkg::sat_inc(line_q);
        col_d  = sxt_pkg::pos_t'(1);
      end else begin
        col_d = sxt_pkg::sat_inc(col_q);
      end
      pos_d = sxt_pkg::sat_inc(pos_q);
    end
  end

  // Pack the tokens into one queue entry, first token in slot 0
  always_comb begin
    if (a_v) begin
      push_data_o.tok0 = tok_a;
      push_data_o.tok1 = tok_b;
      push_data_o.two  = b_v;
    end else begin
      push_data_o.tok0 = tok_b;
      push_data_o.tok1 = tok_b;
      push_data_o.two  = 1'b0;
    end
    push_data_o.tok0.last = !push_data_o.two;
    push_data_o.tok1.last = 1'b1;
  end

  assign push_o = accept && (a_v || b_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= sxt_pkg::MODE_IDLE;
      pos_q    <= '0;
      line_q   <= sxt_pkg::pos_t'(1);
      col_q    <= sxt_pkg::pos_t'(1);
      tstart_q <= '0;
      tline_q  <= sxt_pkg::pos_t'(1);
      tcol_q   <= sxt_pkg::pos_t'(1);
    end else if (accept) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
      col_q    <= col_d;
      tstart_q <= tstart_d;
      tline_q  <= tline_d;
      tcol_q   <= tcol_d;
    end
  end

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_end_i |=> pos_q == '0 && mode_q == sxt_pkg::MODE_IDLE)
    else $error("front did not return to start after end beat");

endmodule

// ===== sv/sxt_fifo.sv =====
// Token queue between scanner front end and output back end.
// Register-based, FIFO_DEPTH entries of pair_t; uses sxt_pkg.
module sxt_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sxt_pkg::pair_t      push_data_i,
  input  logic                pop_i,
  output sxt_pkg::pair_t      pop_data_o,
  output sxt_pkg::fifo_stat_t stat_o
);

  sxt_pkg::pair_t                 mem_q [sxt_pkg::FIFO_DEPTH];
  logic [sxt_pkg::FIFO_AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [sxt_pkg::FIFO_AW:0]      cnt_q;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == (sxt_pkg::FIFO_AW+1)'(sxt_pkg::FIFO_DEPTH));
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into full token queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from empty token queue");

  a_count_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not advance on push");

endmodule

// ===== sv/sxt_back.sv =====
// Output back end: pops queue entries and presents their tokens one beat at a time.
// Holds the current entry in an output register; uses sxt_pkg.
module sxt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sxt_pkg::pair_t      pop_data_i,
  input  sxt_pkg::fifo_stat_t fifo_stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sxt_pkg::token_t     tok_o
);

  sxt_pkg::pair_t pair_q;
  logic           busy_q, busy_d;
  logic           idx_q, idx_d;
  logic           fire, done;

  assign out_valid_o = busy_q;
  assign tok_o       = idx_q ? pair_q.tok1 : pair_q.tok0;
  assign fire        = busy_q && out_ready_i;
  assign done        = fire && (idx_q || !pair_q.two);
  assign pop_o       = (!busy_q || done) && !fifo_stat_i.empty;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (pop_o) begin
      busy_d = 1'b1;
      idx_d  = 1'b0;
    end else if (done) begin
      busy_d = 1'b0;
      idx_d  = 1'b0;
    end else if (fire) begin
      idx_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pair_q <= pop_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !tok_o.last |=> busy_q && idx_q)
    else $error("second token of a byte was lost");

  a_slot1_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && idx_q |-> pair_q.two && tok_o.last)
    else $error("second slot shown without a two-token entry");

endmodule

// ===== sv/s_expression_tokenizer.sv =====
// Top level of the s-expression tokenizer: scanner front end, token queue, output back end.
// Depends on sxt_pkg, sxt_front, sxt_fifo and sxt_back.
//
// The tokenizer takes one source byte per beat (ch_i, or is_end_i to close the source) and
// emits Lisp tokens with kind, start offset, length, line and column. The front end accepts
// a byte every cycle as long as the four-entry token queue has room; each byte gets a
// single-step mode update plus position, line and column counters that saturate at their
// maximum. Each byte yields zero, one or two tokens, queued together as one entry, and the
// back end hands out one token per cycle from its output register while out_ready_i is high,
// so a byte that both closes and opens a token is handed out as two tokens, the closing one
// first. A token is registered in the queue, then in the output register. The end beat
// flushes any open token, emits the end token and returns the scanner to offset 0, line 1,
// column 1. last_of_run_o marks the final token caused by a byte. No clearing pass after
// reset: the block takes bytes right away.
module s_expression_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  input  logic        is_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [23:0] start_offset_o,
  output logic [23:0] lexeme_length_o,
  output logic [23:0] line_number_o,
  output logic [23:0] column_number_o,
  output logic        last_of_run_o
);

  // Queue handshake between front end and back end
  logic                push, pop;
  sxt_pkg::pair_t      push_data, pop_data;
  sxt_pkg::fifo_stat_t fifo_stat;
  sxt_pkg::token_t     tok;

  // Scan bytes and classify them into tokens
  sxt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ch_i        (ch_i),
    .is_end_i    (is_end_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Hold tokens so either side can stall on its own
  sxt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (fifo_stat)
  );

  // Serialize queued entries into one token beat per cycle while out_ready_i is high
  sxt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_data_i  (pop_data),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tok_o       (tok)
  );

  // Drive the payload ports from the current output token
  assign token_kind_o    = tok.kind;
  assign start_offset_o  = 24'(tok.start);
  assign lexeme_length_o = 24'(tok.len);
  assign line_number_o   = 24'(tok.line);
  assign column_number_o = 24'(tok.col);
  assign last_of_run_o   = tok.last;

endmodule
